// ===== rtl/nnt_pkg.sv =====
`default_nettype none

package nnt_pkg;

    localparam int MAX_NODES = 32;

    localparam int NODE_W = 5;
    localparam int DIST_W = 31;
    localparam int CFG_W  = 6;
    localparam int CFG_IDX_W = 1;

    // largest storable distance, one below the all-ones sentinel
    localparam logic [DIST_W-1:0] DIST_SAT = {{(DIST_W-1){1'b1}}, 1'b0};

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_START_NODE = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [NODE_W-1:0] row_node;
        logic [NODE_W-1:0] col_node;
        logic [DIST_W-1:0] distance;
    } nnt_cmd_t;

    typedef struct packed {
        logic [NODE_W-1:0] tour_node;
        logic              is_last;
    } nnt_result_t;

endpackage

`default_nettype wire

// ===== rtl/nearest_neighbor_tour.sv =====
`default_nettype none

// Nearest-neighbor tour builder. A load command (start with opcode 0) writes one
// distance entry in the cycle it is taken and never raises busy, so loads can
// come every cycle while the block is idle. A run command raises busy until the
// closing result has been produced: the first node comes out in the cycle after
// the run is taken, then each further node is found by reading the row of the
// current node from the distance memory one entry per clock and feeding it
// to one shared comparator, followed by a drain and a pick state. The closing
// result comes from the close state after the last pick. Results appear on
// result with result_valid high for exactly one cycle and cannot be held off.
// The distance memory has no reset; entries of the active problem must be loaded
// before a run.

module nearest_neighbor_tour
    import nnt_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire nnt_cmd_t             cmd,
    output logic                      result_valid,
    output nnt_result_t               result,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int NW = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int XW = (CW > CFG_W) ? CW : CFG_W;
    localparam int AW = 2 * NW;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_PICK,
        ST_CLOSE
    } state_t;

    state_t                state_reg, state_next;
    logic [CFG_W-1:0]      node_count_reg;
    logic [NODE_W-1:0]     start_node_reg;
    logic [CW-1:0]         n_reg, n_next;
    logic [NW-1:0]         s_reg, s_next;
    logic [NW-1:0]         cur_reg, cur_next;
    logic [MAX_NODES-1:0]  visited_reg, visited_next;
    logic [CW-1:0]         emitted_reg, emitted_next;
    logic [CW-1:0]         issue_pos_reg, issue_pos_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic [NW-1:0]         rd_idx_reg, rd_idx_next;
    logic [DIST_W-1:0]     best_dist_reg, best_dist_next;
    logic [NW-1:0]         best_node_reg, best_node_next;
    logic                  found_reg, found_next;
    logic                  out_valid_reg, out_valid_next;
    nnt_result_t           out_reg, out_next;

    logic                  accept;
    logic [XW-1:0]         nc_x, n_eff_x, s_x;
    logic [CW-1:0]         n_eff;
    logic [NW-1:0]         s_eff;
    logic [XW-1:0]         row_x, col_x;
    logic [NW-1:0]         row_idx, col_idx;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic [DIST_W-1:0]     mem_wdata, mem_rdata;
    logic                  take;

    function automatic logic [NODE_W-1:0] to_tour(input logic [NW-1:0] node);
        logic [XW-1:0] wide;
        wide = XW'(node);
        return wide[NODE_W-1:0];
    endfunction

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // effective node count and start node
    always_comb
    begin
        nc_x = XW'(node_count_reg);
        if (nc_x == '0)
        begin
            n_eff_x = XW'(1);
        end
        else if (nc_x > XW'(MAX_NODES))
        begin
            n_eff_x = XW'(MAX_NODES);
        end
        else
        begin
            n_eff_x = nc_x;
        end
        n_eff = n_eff_x[CW-1:0];
        s_x   = XW'(start_node_reg);
        s_eff = (s_x >= n_eff_x) ? '0 : s_x[NW-1:0];
    end

    // load path
    assign row_x     = XW'(cmd.row_node);
    assign col_x     = XW'(cmd.col_node);
    assign row_idx   = row_x[NW-1:0];
    assign col_idx   = col_x[NW-1:0];
    assign mem_we    = accept && (cmd.opcode == OP_LOAD)
                       && (row_x < XW'(MAX_NODES)) && (col_x < XW'(MAX_NODES));
    assign mem_waddr = {row_idx, col_idx};
    assign mem_wdata = (cmd.distance == '1) ? DIST_SAT : cmd.distance;
    assign mem_raddr = {cur_reg, issue_pos_reg[NW-1:0]};

    nnt_dist_mem #(
        .ADDR_W (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // shared comparator on the registered read data
    assign take = rd_valid_reg && !visited_reg[rd_idx_reg] && (mem_rdata < best_dist_reg);

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        s_next         = s_reg;
        cur_next       = cur_reg;
        visited_next   = visited_reg;
        emitted_next   = emitted_reg;
        issue_pos_next = issue_pos_reg;
        rd_valid_next  = 1'b0;
        rd_idx_next    = rd_idx_reg;
        best_dist_next = best_dist_reg;
        best_node_next = best_node_reg;
        found_next     = found_reg;
        out_valid_next = 1'b0;
        out_next       = out_reg;

        if (take)
        begin
            best_dist_next = mem_rdata;
            best_node_next = rd_idx_reg;
            found_next     = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd.opcode == OP_RUN))
                begin
                    n_next                = n_eff;
                    s_next                = s_eff;
                    cur_next              = s_eff;
                    visited_next          = '0;
                    visited_next[s_eff]   = 1'b1;
                    emitted_next          = CW'(1);
                    out_valid_next        = 1'b1;
                    out_next.tour_node    = to_tour(s_eff);
                    out_next.is_last      = 1'b0;
                    issue_pos_next        = '0;
                    best_dist_next        = '1;
                    best_node_next        = '0;
                    found_next            = 1'b0;
                    state_next            = (n_eff > CW'(1)) ? ST_SCAN : ST_CLOSE;
                end
            end
            ST_SCAN:
            begin
                rd_valid_next  = 1'b1;
                rd_idx_next    = issue_pos_reg[NW-1:0];
                issue_pos_next = issue_pos_reg + CW'(1);
                if (issue_pos_reg == n_reg - CW'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                if (found_reg)
                begin
                    cur_next                    = best_node_reg;
                    visited_next[best_node_reg] = 1'b1;
                    emitted_next                = emitted_reg + CW'(1);
                    out_valid_next              = 1'b1;
                    out_next.tour_node          = to_tour(best_node_reg);
                    out_next.is_last            = 1'b0;
                    issue_pos_next              = '0;
                    best_dist_next              = '1;
                    best_node_next              = '0;
                    found_next                  = 1'b0;
                    state_next = (emitted_reg + CW'(1) < n_reg) ? ST_SCAN : ST_CLOSE;
                end
                else
                begin
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE:
            begin
                out_valid_next     = 1'b1;
                out_next.tour_node = to_tour(s_reg);
                out_next.is_last   = 1'b1;
                state_next         = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            visited_reg   <= '0;
            cur_reg       <= '0;
            best_dist_reg <= '1;
            best_node_reg <= '0;
            issue_pos_reg <= '0;
            emitted_reg   <= '0;
            found_reg     <= 1'b0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            visited_reg   <= visited_next;
            cur_reg       <= cur_next;
            best_dist_reg <= best_dist_next;
            best_node_reg <= best_node_next;
            issue_pos_reg <= issue_pos_next;
            emitted_reg   <= emitted_next;
            found_reg     <= found_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        s_reg      <= s_next;
        rd_idx_reg <= rd_idx_next;
        out_reg    <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= CFG_W'(32);
            start_node_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NODE_COUNT: node_count_reg <= cfg_data;
                REG_START_NODE: start_node_reg <= cfg_data[NODE_W-1:0];
                default:        node_count_reg <= node_count_reg;
            endcase
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // one visited mark per node already sent out
    a_visit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_DRAIN || state_reg == ST_PICK)
        |-> ($countones(visited_reg) == emitted_reg))
        else $error("visited marks out of step with emitted count");

    a_read_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> ($past(state_reg) == ST_SCAN))
        else $error("read data valid outside a scan");

    a_pick_unvisited: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PICK && found_reg) |-> !visited_reg[best_node_reg])
        else $error("chosen node already visited");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (issue_pos_reg < n_reg))
        else $error("scan ran past the active node count");

    a_close_start: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.is_last) |-> (result.tour_node == to_tour(s_reg)))
        else $error("closing result is not the start node");

endmodule

`default_nettype wire

// ===== rtl/nnt_dist_mem.sv =====
`default_nettype none

module nnt_dist_mem
    import nnt_pkg::*;
#(
    parameter int ADDR_W = 10
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DIST_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DIST_W-1:0] rdata
);

    logic [DIST_W-1:0] mem [1 << ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
